// ===== hdl/usvs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usvs_pkg: shared definitions for the unique value set store
// Sizes, status codes, register map and the command word that the top level
// broadcasts along the chain of storage cells.
// ----------------------------------------------------------------------------
package usvs_pkg;

    // Built storage depth and derived widths.
    localparam int DEPTH    = 16;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W    = 5;
    localparam int LIM_W    = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;
    localparam int ACTION_W = 1;
    localparam int STATUS_W = 3;
    localparam int ECOUNT_W = 5;

    // Configuration port.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY_LIMIT = 1'b0;
    localparam logic [CAP_W-1:0]     CAP_RESET          = 5'd16;

    // Operation codes.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 1'b1;

    // Result status codes.
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_DUPLICATE = 3'd1;
    localparam status_t ST_FULL      = 3'd2;
    localparam status_t ST_REMOVED   = 3'd3;
    localparam status_t ST_NOT_FOUND = 3'd4;

    // Command word seen by every cell in the same cycle.
    typedef struct packed {
        logic               insert_wr;
        logic               remove_op;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } usvs_cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/usvs_cmd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usvs_cmd_if: command channel of the unique value set store
// Valid/ready channel carrying one insert or remove request per word.
// ----------------------------------------------------------------------------
interface usvs_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [usvs_pkg::ACTION_W-1:0]         action;
    logic signed [usvs_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface
`default_nettype wire

// ===== hdl/usvs_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usvs_rsp_if: result channel of the unique value set store
// Valid/ready channel carrying a status and the element count per word.
// ----------------------------------------------------------------------------
interface usvs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [usvs_pkg::STATUS_W-1:0]   status;
    logic [usvs_pkg::ECOUNT_W-1:0]   element_count;

    modport source (output valid, output status, output element_count, input ready);
    modport sink   (input valid, input status, input element_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/usvs_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usvs_cell: one storage cell of the set
// Holds one element, compares it against the broadcast value, extends the
// match chain and takes its upper neighbor's element when a remove closes a gap.
// ----------------------------------------------------------------------------
module usvs_cell
(
    input  wire logic                               clk,
    input  wire logic [usvs_pkg::IDX_W-1:0]         cell_idx,
    input  wire usvs_pkg::usvs_cell_cmd_t           cmd,
    input  wire logic                               match_in,
    input  wire logic [usvs_pkg::VALUE_W-1:0]       next_data,
    output logic                                    hit,
    output logic                                    match_out,
    output logic [usvs_pkg::VALUE_W-1:0]            data_out
);

    import usvs_pkg::*;

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               live;
    logic               at_tail;

    // A cell holds an element only while its index is below the count.
    assign live      = COUNT_W'(cell_idx) < cmd.count;
    assign at_tail   = COUNT_W'(cell_idx) == cmd.count;
    assign hit       = live && (data_reg == cmd.value);
    assign match_out = match_in | hit;
    assign data_out  = data_reg;

    // Insert fills the tail cell; a remove shifts the match and above down one.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.insert_wr && at_tail)
        begin
            data_next = cmd.value;
        end
        else if (cmd.remove_op && match_out)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== hdl/unique_value_set_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unique_value_set_store: fixed-capacity set of distinct 32-bit values
// Insert and remove requests against a row of cells kept in insertion order.
// ----------------------------------------------------------------------------
// Each command word is compared against all held elements at once through
// the row of DEPTH cells, whose match chain ripples from the first cell to
// the last and sets the clock period. The result appears in the output
// register in the cycle after the command is accepted, and a new command is
// accepted in every cycle in which the output register is empty or being
// drained. An insert answers full when the count has reached the lesser of
// capacity_limit and DEPTH, then duplicate on a match, else it appends. A
// remove shifts all later elements down one cell. Write capacity_limit only
// while no command is in flight.
module unique_value_set_store
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    usvs_cmd_if.sink                            cmd,
    usvs_rsp_if.source                          result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [usvs_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [usvs_pkg::PDATA_W-1:0]   pwdata,
    output logic [usvs_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    import usvs_pkg::*;

    logic [CAP_W-1:0]   cap_reg;
    logic [CAP_W-1:0]   cap_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    status_t            status_reg;
    status_t            status_next;

    logic                   accept;
    logic                   cfg_wr;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic [LIM_W-1:0]       eff_limit;
    logic                   full;
    logic                   found;
    logic                   is_remove;
    usvs_cell_cmd_t         cell_cmd;
    logic [DEPTH:0]         match_chain;
    logic [DEPTH-1:0]       hit_vec;
    logic [VALUE_W-1:0]     cell_data [DEPTH];

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_wr && (reg_idx == REG_CAPACITY_LIMIT))
        begin
            cap_next = pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_CAPACITY_LIMIT)
        begin
            prdata = PDATA_W'(cap_reg);
        end
    end

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    assign cmd.ready = !rsp_valid_reg || result.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign is_remove = (cmd.action == ACT_REMOVE);

    assign eff_limit = (LIM_W'(cap_reg) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(cap_reg);
    assign full      = LIM_W'(count_reg) >= eff_limit;
    assign found     = match_chain[DEPTH];

    assign cell_cmd.insert_wr = accept && !is_remove && !full && !found;
    assign cell_cmd.remove_op = accept && is_remove;
    assign cell_cmd.value     = cmd.value;
    assign cell_cmd.count     = count_reg;

    // ------------------------------------------------------------------
    // Row of cells
    // ------------------------------------------------------------------
    assign match_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [VALUE_W-1:0] upper_data;

            if (gi == DEPTH - 1)
            begin : g_last
                assign upper_data = '0;
            end
            else
            begin : g_mid
                assign upper_data = cell_data[gi + 1];
            end

            usvs_cell u_cell
            (
                .clk       (clk),
                .cell_idx  (IDX_W'(gi)),
                .cmd       (cell_cmd),
                .match_in  (match_chain[gi]),
                .next_data (upper_data),
                .hit       (hit_vec[gi]),
                .match_out (match_chain[gi + 1]),
                .data_out  (cell_data[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Count and result
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next = count_reg;
        if (cell_cmd.insert_wr)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cell_cmd.remove_op && found)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_comb
    begin
        if (is_remove)
        begin
            status_next = found ? ST_REMOVED : ST_NOT_FOUND;
        end
        else if (full)
        begin
            status_next = ST_FULL;
        end
        else if (found)
        begin
            status_next = ST_DUPLICATE;
        end
        else
        begin
            status_next = ST_INSERTED;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    // The count changes only when a new result is loaded, so it is the result.
    assign result.valid         = rsp_valid_reg;
    assign result.status        = status_reg;
    assign result.element_count = ECOUNT_W'(count_reg);

`ifndef SYNTHESIS
    // Held elements are distinct, so no value can match two cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> $onehot0(hit_vec))
        else $error("usvs: value matched more than one cell");

    // The count never exceeds the built depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        LIM_W'(count_reg) <= LIM_W'(DEPTH))
        else $error("usvs: element count above depth");

    // An insert refused for lack of room leaves the count alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_remove && full) |=> (count_reg == $past(count_reg)))
        else $error("usvs: count changed on a full insert");

    // A remove of a held value lowers the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_remove && found) |=> (count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("usvs: count not lowered on remove");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_unique_value_set_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unique_value_set_store: self-checking bench for the unique value set store
// A directed table covers the edges of the set: empty removes, extreme values,
// duplicates, a full set, limits above the depth, at zero and below the count,
// and a write to an unused register. Long random phases follow, each with its
// own capacity limit and idling pattern. A set model inside the bench predicts
// every result word, and each one is compared in order as it is drained.
// ----------------------------------------------------------------------------
module tb_unique_value_set_store;
    import usvs_pkg::*;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int TAIL_CYCLES      = 8;
    localparam int MAX_REPORTS      = 10;
    localparam int UNUSED_REG_INDEX = 1;
    localparam int PHASE_COUNT      = 10;
    localparam int PHASE_ITEMS      = 110;
    localparam int POOL_SIZE        = 20;

    typedef struct packed {
        status_t             status;
        logic [ECOUNT_W-1:0] count;
    } set_result_t;

    typedef enum { ROW_ITEM, ROW_CONFIG } row_kind_t;
    typedef enum { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    typedef struct {
        row_kind_t            kind;
        logic [ACTION_W-1:0]  action;
        logic [VALUE_W-1:0]   value;
        int                   reg_index;
        bit                   fixed_expect;
        set_result_t          want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    usvs_cmd_if cmd_bus ();
    usvs_rsp_if result_bus ();

    unique_value_set_store dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model of the set: held elements in insertion order and the limit register.
    logic [VALUE_W-1:0] held_values[$];
    logic [CAP_W-1:0]   limit_reg;

    set_result_t        pending_results[$];
    stim_row_t          dir_rows[$];
    logic [VALUE_W-1:0] value_pool[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int fail_count;
    int stall_cycles;
    set_result_t head_expect;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int effective_limit();
        return (limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
    endfunction

    function automatic set_result_t apply_set_op(input logic [ACTION_W-1:0] act,
                                                 input logic [VALUE_W-1:0] v);
        int hit;
        set_result_t r;
        hit = -1;
        foreach (held_values[i])
            if (hit < 0 && held_values[i] == v)
                hit = i;
        if (act == ACT_INSERT)
        begin
            // The capacity check wins over the duplicate check.
            if (held_values.size() >= effective_limit())
                r.status = ST_FULL;
            else if (hit >= 0)
                r.status = ST_DUPLICATE;
            else
            begin
                held_values.push_back(v);
                r.status = ST_INSERTED;
            end
        end
        else if (hit >= 0)
        begin
            held_values.delete(hit);
            r.status = ST_REMOVED;
        end
        else
            r.status = ST_NOT_FOUND;
        r.count = ECOUNT_W'(held_values.size());
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic [ACTION_W-1:0] act,
                                           input logic [VALUE_W-1:0] v);
        stim_row_t row;
        row.kind = ROW_ITEM;
        row.action = act;
        row.value = v;
        row.reg_index = 0;
        row.fixed_expect = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic [ACTION_W-1:0] act,
                                            input logic [VALUE_W-1:0] v,
                                            input status_t st, input int cnt);
        stim_row_t row;
        row = item_row(act, v);
        row.fixed_expect = 1'b1;
        row.want.status = st;
        row.want.count = ECOUNT_W'(cnt);
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input int index, input logic [PDATA_W-1:0] data);
        stim_row_t row;
        row = item_row(ACT_INSERT, data);
        row.kind = ROW_CONFIG;
        row.reg_index = index;
        return row;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        sender_idle_pct = (mode == IDLE_SENDER) ? 88 : (mode == IDLE_BOTH) ? 9 : 0;
        receiver_stall_pct = (mode == IDLE_RECEIVER) ? 88 : (mode == IDLE_BOTH) ? 9 : 0;
    endtask

    // Drives one word and holds it until accepted; the expectation is queued
    // at the accepting edge.
    task automatic send_command(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] v,
                                input bit fixed_expect, input set_result_t want);
        set_result_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.action <= act;
        cmd_bus.value  <= v;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        predicted = apply_set_op(act, v);
        pending_results.push_back(fixed_expect ? want : predicted);
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input int index, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(index << 2);
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_register(input int index, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] readback;
        apb_access(1'b1, index, data, readback);
        if (index == int'(REG_CAPACITY_LIMIT))
        begin
            limit_reg = data[CAP_W-1:0];
            apb_access(1'b0, index, '0, readback);
            if (readback !== PDATA_W'(limit_reg))
                note_failure($sformatf("capacity_limit reads back %0h, expected %0h",
                                       readback, limit_reg));
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return value_pool[$urandom_range(value_pool.size() - 1)];
        if (roll < 75 && held_values.size() != 0)
            return held_values[$urandom_range(held_values.size() - 1)];
        if (roll < 92)
            return $urandom;
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    always @(negedge clk)
        result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("result word status %0d count %0d with none expected",
                                       result_bus.status, result_bus.element_count));
            else
            begin
                head_expect = pending_results.pop_front();
                if (result_bus.status !== head_expect.status ||
                    result_bus.element_count !== head_expect.count)
                    note_failure($sformatf("expected status %0d count %0d, got %0d count %0d",
                                           head_expect.status, head_expect.count,
                                           result_bus.status, result_bus.element_count));
            end
        end
    end

    // Ends the run if nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if (!rst_n || psel || (cmd_bus.valid && cmd_bus.ready) ||
            (result_bus.valid && result_bus.ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int phase_limits[PHASE_COUNT];
        logic [ACTION_W-1:0] act;
        set_result_t none;

        phase_limits = '{31, 16, 1, 17, 5, 0, 16, 8, 31, 2};
        none = '0;
        fail_count = 0;
        stall_cycles = 0;
        limit_reg = CAP_RESET;
        set_idle_mode(IDLE_NONE);
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.action = ACT_INSERT;
        cmd_bus.value = '0;
        result_bus.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        dir_rows.push_back(known_row(ACT_REMOVE, 32'd5,         ST_NOT_FOUND, 0));
        dir_rows.push_back(known_row(ACT_INSERT, 32'h8000_0000, ST_INSERTED,  1));
        dir_rows.push_back(known_row(ACT_INSERT, 32'h7FFF_FFFF, ST_INSERTED,  2));
        dir_rows.push_back(item_row (ACT_INSERT, 32'h0000_0000));
        dir_rows.push_back(item_row (ACT_INSERT, 32'hFFFF_FFFF));
        dir_rows.push_back(known_row(ACT_INSERT, 32'h7FFF_FFFF, ST_DUPLICATE, 4));
        dir_rows.push_back(item_row (ACT_REMOVE, 32'h0000_0000));
        dir_rows.push_back(known_row(ACT_REMOVE, 32'h0000_0000, ST_NOT_FOUND, 3));
        // The cell freed at the end keeps stale data that is not live; zero must still be inserted.
        dir_rows.push_back(item_row (ACT_INSERT, 32'h0000_0000));
        dir_rows.push_back(cfg_row  (int'(REG_CAPACITY_LIMIT), 32'hFFFF_FFE4));
        dir_rows.push_back(known_row(ACT_INSERT, 32'h0000_0001, ST_FULL,      4));
        dir_rows.push_back(known_row(ACT_INSERT, 32'hFFFF_FFFF, ST_FULL,      4));
        dir_rows.push_back(cfg_row  (int'(REG_CAPACITY_LIMIT), 32'd2));
        dir_rows.push_back(known_row(ACT_INSERT, 32'h0000_0002, ST_FULL,      4));
        dir_rows.push_back(item_row (ACT_REMOVE, 32'h8000_0000));
        dir_rows.push_back(known_row(ACT_INSERT, 32'h0000_0005, ST_FULL,      3));
        dir_rows.push_back(cfg_row  (int'(REG_CAPACITY_LIMIT), 32'd0));
        dir_rows.push_back(known_row(ACT_INSERT, 32'h0000_0006, ST_FULL,      3));
        dir_rows.push_back(item_row (ACT_REMOVE, 32'h0000_0000));
        dir_rows.push_back(item_row (ACT_REMOVE, 32'hFFFF_FFFF));
        dir_rows.push_back(item_row (ACT_REMOVE, 32'h7FFF_FFFF));
        dir_rows.push_back(known_row(ACT_REMOVE, 32'h7FFF_FFFF, ST_NOT_FOUND, 0));
        dir_rows.push_back(cfg_row  (UNUSED_REG_INDEX, 32'd16));
        dir_rows.push_back(known_row(ACT_INSERT, 32'h0000_0001, ST_FULL,      0));
        dir_rows.push_back(cfg_row  (int'(REG_CAPACITY_LIMIT), 32'd31));
        dir_rows.push_back(item_row (ACT_INSERT, 32'h5555_AAAA));
        dir_rows.push_back(item_row (ACT_INSERT, 32'hAAAA_5555));
        dir_rows.push_back(item_row (ACT_REMOVE, 32'h5555_AAAA));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CONFIG)
            begin
                drain_results();
                write_register(dir_rows[i].reg_index, dir_rows[i].value);
            end
            else
                send_command(dir_rows[i].action, dir_rows[i].value,
                             dir_rows[i].fixed_expect, dir_rows[i].want);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain_results();
            write_register(int'(REG_CAPACITY_LIMIT), phase_limits[p]);
            set_idle_mode(idle_mode_t'(p % 4));
            value_pool.delete();
            for (int k = 0; k < POOL_SIZE; k++)
                value_pool.push_back((k % 2 == 0) ? $urandom : 32'($urandom_range(15)) - 32'd8);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Halfway through, hold off until the set has answered everything.
                if (n == PHASE_ITEMS / 2)
                    drain_results();
                if (held_values.size() < effective_limit())
                    act = ($urandom_range(99) < 65) ? ACT_INSERT : ACT_REMOVE;
                else
                    act = ($urandom_range(99) < 35) ? ACT_INSERT : ACT_REMOVE;
                send_command(act, pick_value(), 1'b0, none);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/usvs_pkg.sv
hdl/usvs_cmd_if.sv
hdl/usvs_rsp_if.sv
hdl/usvs_cell.sv
hdl/unique_value_set_store.sv
tb/tb_unique_value_set_store.sv
